[design/multipart_boundary_stripper_assert.svh]
// ----------------------------------------------------------------------------
// multipart_boundary_stripper_assert.svh
// Assertion macros for the multipart boundary stripper.
// ----------------------------------------------------------------------------
`ifndef MULTIPART_BOUNDARY_STRIPPER_ASSERT_SVH
`define MULTIPART_BOUNDARY_STRIPPER_ASSERT_SVH

// Same-cycle implication.
`define MBS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/mbs_pkg.sv]
// ----------------------------------------------------------------------------
// mbs_pkg
// Shared types and constants of the multipart boundary stripper.
// ----------------------------------------------------------------------------
package mbs_pkg;

  localparam int LEN_W          = 6;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 64;
  localparam int WORD_BYTES     = 8;
  localparam int KEY_BYTES_DEF  = 56;
  localparam int KEY_LENGTH_RST = 1;

  localparam int REG_KEY_LENGTH    = 0;
  localparam int REG_KEY_WORD_BASE = 1;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

[design/mbs_if.sv]
// ----------------------------------------------------------------------------
// mbs_in_if / mbs_out_if
// Valid/ready channels for body bytes and stripped results.
// ----------------------------------------------------------------------------
interface mbs_in_if;
  logic          valid;
  logic          ready;
  mbs_pkg::byte_t data_byte;
  logic          end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface mbs_out_if;
  logic          valid;
  logic          ready;
  mbs_pkg::byte_t out_byte;
  logic          boundary_found;
  logic          last_of_run;

  modport source (output valid, output out_byte, output boundary_found,
                  output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input boundary_found,
                  input last_of_run, output ready);
endinterface

[design/mbs_key_store.sv]
// ----------------------------------------------------------------------------
// mbs_key_store
// Boundary key registers, effective key length and one byte read port.
// ----------------------------------------------------------------------------
module mbs_key_store #(
  parameter int KEY_BYTES = mbs_pkg::KEY_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mbs_pkg::cfg_wr_t              cfg,
  input  logic [$clog2(KEY_BYTES)-1:0]  rd_addr,
  output mbs_pkg::byte_t                rd_byte,
  output logic [mbs_pkg::LEN_W-1:0]     eff_len
);

  localparam int KEY_WORDS = (KEY_BYTES + mbs_pkg::WORD_BYTES - 1) / mbs_pkg::WORD_BYTES;
  localparam int WORD_W    = mbs_pkg::WORD_BYTES * 8;

  logic [mbs_pkg::LEN_W-1:0] key_length_r;
  logic [WORD_W-1:0]         key_word_r [KEY_WORDS];
  mbs_pkg::byte_t            key_bytes  [KEY_WORDS*mbs_pkg::WORD_BYTES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r <= mbs_pkg::LEN_W'(mbs_pkg::KEY_LENGTH_RST);
    end else if (cfg.we && cfg.index == mbs_pkg::CFG_IDX_W'(mbs_pkg::REG_KEY_LENGTH)) begin
      key_length_r <= cfg.data[mbs_pkg::LEN_W-1:0];
    end
  end

  for (genvar w = 0; w < KEY_WORDS; w++) begin : g_word
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        key_word_r[w] <= '0;
      end else if (cfg.we &&
                   cfg.index == mbs_pkg::CFG_IDX_W'(mbs_pkg::REG_KEY_WORD_BASE + w)) begin
        key_word_r[w] <= cfg.data[WORD_W-1:0];
      end
    end
    for (genvar b = 0; b < mbs_pkg::WORD_BYTES; b++) begin : g_byte
      assign key_bytes[w*mbs_pkg::WORD_BYTES+b] = key_word_r[w][b*8 +: 8];
    end
  end

  assign rd_byte = key_bytes[rd_addr];

  always_comb begin
    if (key_length_r == '0) begin
      eff_len = mbs_pkg::LEN_W'(1);
    end else if (key_length_r > mbs_pkg::LEN_W'(KEY_BYTES)) begin
      eff_len = mbs_pkg::LEN_W'(KEY_BYTES);
    end else begin
      eff_len = key_length_r;
    end
  end

endmodule

[design/multipart_boundary_stripper.sv]
// ----------------------------------------------------------------------------
// multipart_boundary_stripper
// Passes body bytes through, holds bytes that match the boundary key so far
// and replaces a full match by one boundary marker.
// ----------------------------------------------------------------------------
// channel | dir | payload                                    | per transfer
// in_ch   | in  | data_byte, end_of_stream                   | one body byte
// out_ch  | out | out_byte, boundary_found, last_of_run       | one result
// cfg_*   | in  | cfg_we, cfg_index, cfg_data                | one register write
//
// Each byte is compared in S_TEST, then held, ends a match or goes to S_EMIT;
// a mismatch after m held bytes runs S_RETEST and S_FLUSH, which emits the m
// held bytes, and the byte is then held again or passed: the sequencer
// compares against one key byte per cycle through a single read port.
// Reset is synchronous; key_length resets to 1, key words to 0.
// A stalled out_ch holds the sequencer in its emitting state; in_ch is
// ready only while the sequencer is idle, even with a result still waiting.
// ----------------------------------------------------------------------------
module multipart_boundary_stripper #(
  parameter int KEY_BYTES = mbs_pkg::KEY_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  mbs_in_if.sink                         in_ch,
  mbs_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [mbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbs_pkg::CFG_DATA_W-1:0] cfg_data
);

`include "multipart_boundary_stripper_assert.svh"

  localparam int KB_AW = $clog2(KEY_BYTES);
  localparam int LW    = mbs_pkg::LEN_W;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_TEST   = 5'b00010,
    S_RETEST = 5'b00100,
    S_FLUSH  = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  mbs_pkg::byte_t   byte_r, byte_nxt;
  logic             eos_r, eos_nxt;
  logic             hit_r, hit_nxt;
  logic [LW-1:0]    cnt_r, cnt_nxt;
  logic [LW-1:0]    m_r, m_nxt;
  logic [LW-1:0]    idx_r, idx_nxt;

  logic             out_valid_r, out_valid_nxt;
  mbs_pkg::byte_t   out_byte_r;
  logic             out_bnd_r;
  logic             out_last_r;

  logic             load;
  mbs_pkg::byte_t   ld_byte;
  logic             ld_bnd;
  logic             ld_last;

  mbs_pkg::cfg_wr_t cfg;
  logic [KB_AW-1:0] rd_addr;
  mbs_pkg::byte_t   key_rd;
  logic [LW-1:0]    eff_len;
  logic             in_xfer;
  logic             slot_free;
  logic             key_eq;
  logic [LW-1:0]    m_inc;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  mbs_key_store #(
    .KEY_BYTES (KEY_BYTES)
  ) u_key (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .rd_addr (rd_addr),
    .rd_byte (key_rd),
    .eff_len (eff_len)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign key_eq      = (key_rd == byte_r);
  assign m_inc       = m_r + LW'(1);

  always_comb begin
    case (state_r)
      S_TEST:  rd_addr = m_r[KB_AW-1:0];
      S_FLUSH: rd_addr = idx_r[KB_AW-1:0];
      default: rd_addr = '0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    byte_nxt  = byte_r;
    eos_nxt   = eos_r;
    hit_nxt   = hit_r;
    cnt_nxt   = cnt_r;
    m_nxt     = m_r;
    idx_nxt   = idx_r;
    load      = 1'b0;
    ld_byte   = byte_r;
    ld_bnd    = 1'b0;
    ld_last   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          byte_nxt  = in_ch.data_byte;
          eos_nxt   = in_ch.end_of_stream;
          m_nxt     = (cnt_r >= eff_len) ? '0 : cnt_r;
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        if (key_eq) begin
          if (m_inc == eff_len) begin
            if (slot_free) begin
              load      = 1'b1;
              ld_byte   = '0;
              ld_bnd    = 1'b1;
              ld_last   = 1'b1;
              cnt_nxt   = '0;
              state_nxt = S_IDLE;
            end
          end else begin
            cnt_nxt   = eos_r ? '0 : m_inc;
            state_nxt = S_IDLE;
          end
        end else if (m_r != '0) begin
          state_nxt = S_RETEST;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_RETEST: begin
        hit_nxt   = key_eq;
        idx_nxt   = '0;
        state_nxt = S_FLUSH;
      end
      S_FLUSH: begin
        if (slot_free) begin
          load    = 1'b1;
          ld_byte = key_rd;
          ld_last = hit_r && (idx_r == m_r - LW'(1));
          idx_nxt = idx_r + LW'(1);
          if (idx_r == m_r - LW'(1)) begin
            if (hit_r) begin
              cnt_nxt   = eos_r ? '0 : LW'(1);
              state_nxt = S_IDLE;
            end else begin
              state_nxt = S_EMIT;
            end
          end
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          load      = 1'b1;
          ld_byte   = byte_r;
          ld_last   = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    eos_r  <= eos_nxt;
    hit_r  <= hit_nxt;
    m_r    <= m_nxt;
    idx_r  <= idx_nxt;
    if (load) begin
      out_byte_r <= ld_byte;
      out_bnd_r  <= ld_bnd;
      out_last_r <= ld_last;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.out_byte       = out_byte_r;
  assign out_ch.boundary_found = out_bnd_r;
  assign out_ch.last_of_run    = out_last_r;

  `MBS_ASSERT_NOW(a_marker_last, out_ch.valid && out_ch.boundary_found,
    out_ch.last_of_run && out_ch.out_byte == '0, "boundary marker not last or nonzero")
  `MBS_ASSERT_NEXT(a_accept_test, in_xfer, state_r == S_TEST && !in_ch.ready,
    "accepted byte did not start a compare")
  `MBS_ASSERT_NOW(a_flush_range, state_r == S_FLUSH, idx_r < m_r && m_r != '0,
    "flush index outside held prefix")
  `MBS_ASSERT_NOW(a_cnt_range, state_r == S_IDLE, cnt_r < LW'(KEY_BYTES),
    "held count beyond key size")

endmodule

[tb/mbs_checker.sv]
// ----------------------------------------------------------------------------
// mbs_checker
// Watches the body byte channel and the config port, predicts the stripped
// output stream and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module mbs_checker import mbs_pkg::*; #(
  parameter int KEY_BYTES = KEY_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mbs_in_if                     in_ch,
  mbs_out_if                    out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    error_count,
  output int                    pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEY_WORD_COUNT = 7;

  typedef struct packed {
    byte_t out_byte;
    logic  boundary_found;
    logic  last_of_run;
  } strip_result_t;

  strip_result_t         stripped_stream[$];
  logic [LEN_W-1:0]      key_length_reg;
  logic [CFG_DATA_W-1:0] key_word_reg[KEY_WORD_COUNT];
  logic [LEN_W-1:0]      held_count;

  function automatic byte_t key_byte_at(int idx);
    if (idx / WORD_BYTES >= KEY_WORD_COUNT) return '0;
    return key_word_reg[idx / WORD_BYTES][(idx % WORD_BYTES) * 8 +: 8];
  endfunction

  function automatic int active_length();
    int len;
    len = key_length_reg;
    if (len == 0) len = 1;
    if (len > KEY_BYTES) len = KEY_BYTES;
    return len;
  endfunction

  function automatic void emit_result(byte_t value, logic marker);
    stripped_stream.push_back('{out_byte: value, boundary_found: marker, last_of_run: 1'b0});
  endfunction

  function automatic void strip_body_byte(byte_t value, logic last);
    int len;
    int held;
    int first;
    len   = active_length();
    held  = held_count;
    first = stripped_stream.size();
    if (held >= len) held = 0;
    if (value == key_byte_at(held)) begin
      held++;
      if (held == len) begin
        emit_result(8'h00, 1'b1);
        held = 0;
      end
    end else if (held != 0) begin
      for (int i = 0; i < held; i++) emit_result(key_byte_at(i), 1'b0);
      held = 0;
      if (value == key_byte_at(0)) held = 1;
      else emit_result(value, 1'b0);
    end else begin
      emit_result(value, 1'b0);
    end
    if (last) held = 0;
    held_count = held[LEN_W-1:0];
    if (stripped_stream.size() > first)
      stripped_stream[stripped_stream.size() - 1].last_of_run = 1'b1;
  endfunction

  always @(posedge clk) begin
    strip_result_t exp;
    if (!rst_n) begin
      key_length_reg = LEN_W'(KEY_LENGTH_RST);
      foreach (key_word_reg[w]) key_word_reg[w] = '0;
      held_count = '0;
      stripped_stream.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_KEY_LENGTH) key_length_reg = cfg_data[LEN_W-1:0];
        else key_word_reg[int'(cfg_index) - REG_KEY_WORD_BASE] = cfg_data;
      end
      if (in_ch.valid && in_ch.ready)
        strip_body_byte(in_ch.data_byte, in_ch.end_of_stream);
      if (out_ch.valid && out_ch.ready) begin
        if (stripped_stream.size() == 0) begin
          $error("unexpected result: out_byte %0h boundary_found %0b last_of_run %0b",
                 out_ch.out_byte, out_ch.boundary_found, out_ch.last_of_run);
          error_count++;
        end else begin
          exp = stripped_stream.pop_front();
          if (out_ch.out_byte !== exp.out_byte) begin
            $error("out_byte: expected %0h, got %0h", exp.out_byte, out_ch.out_byte);
            error_count++;
          end
          if (out_ch.boundary_found !== exp.boundary_found) begin
            $error("boundary_found: expected %0b, got %0b",
                   exp.boundary_found, out_ch.boundary_found);
            error_count++;
          end
          if (out_ch.last_of_run !== exp.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", exp.last_of_run, out_ch.last_of_run);
            error_count++;
          end
        end
      end
    end
    pending_results = stripped_stream.size();
  end

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Drives body byte streams and boundary keys into the stripper: a directed
// pass over matches, flushes, restarts and end of stream, then random keys
// and streams built mostly from key prefixes, under random backpressure.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mbs_pkg::*;

  localparam int KEY_BYTES       = KEY_BYTES_DEF;
  localparam int KEY_WORD_COUNT  = 7;
  localparam int SETTLE_CYCLES   = 80;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int CYCLE_LIMIT     = 1_200_000;
  localparam byte_t DASH         = 8'h2D;
  localparam byte_t NARROW_SET[3] = '{8'h2D, 8'h00, 8'hFF};

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    error_count;
  int                    pending_results;
  int unsigned           cycle_count;

  byte_t key_pattern[KEY_WORD_COUNT * WORD_BYTES];
  int    key_span;
  int    sender_idle_pct;
  int    stall_pct;
  bit    steady_tail;
  bit    hold_off_req;

  mbs_in_if  in_ch();
  mbs_out_if out_ch();

  multipart_boundary_stripper #(.KEY_BYTES(KEY_BYTES)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mbs_checker #(.KEY_BYTES(KEY_BYTES)) u_strip_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .error_count     (error_count),
    .pending_results (pending_results)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side backpressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
      end else if (!steady_tail && $urandom_range(0, 99) < stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 10)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(int idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data  <= value;
    if (idx == REG_KEY_LENGTH) begin
      key_span = value[LEN_W-1:0];
      if (key_span == 0) key_span = 1;
      if (key_span > KEY_BYTES) key_span = KEY_BYTES;
    end else begin
      for (int b = 0; b < WORD_BYTES; b++)
        key_pattern[(idx - REG_KEY_WORD_BASE) * WORD_BYTES + b] = value[b * 8 +: 8];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_byte(byte_t value, logic last);
    int gap;
    gap = (steady_tail || $urandom_range(0, 99) >= sender_idle_pct) ? 0 : $urandom_range(1, 11);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.data_byte     <= value;
    in_ch.end_of_stream <= last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // block may still be chewing on a held byte after the last result
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending_results == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_key(int raw_len, bit narrow);
    logic [CFG_DATA_W-1:0] word;
    for (int w = 0; w < KEY_WORD_COUNT; w++) begin
      for (int b = 0; b < WORD_BYTES; b++)
        word[b * 8 +: 8] = narrow ? NARROW_SET[$urandom_range(0, 2)] : 8'($urandom_range(0, 255));
      write_reg(REG_KEY_WORD_BASE + w, word);
    end
    write_reg(REG_KEY_LENGTH, CFG_DATA_W'(raw_len));
  endtask

  task automatic run_phase(int raw_len, bit narrow, int item_budget, bit with_hold);
    int sent;
    int cut;
    int kind;
    load_key(raw_len, narrow);
    sender_idle_pct = steady_tail ? 0 : 20 * $urandom_range(0, 2);
    stall_pct       = steady_tail ? 0 : 10 * $urandom_range(0, 3);
    sent = 0;
    while (sent < item_budget) begin
      if (with_hold && sent >= 10) begin
        hold_off_req = 1'b1;
        with_hold = 1'b0;
      end
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        for (int i = 0; i < key_span; i++)
          send_byte(key_pattern[i], i == key_span - 1 && $urandom_range(0, 9) == 0);
        sent += key_span;
      end else if (kind < 6 && key_span > 1) begin
        cut = $urandom_range(1, key_span - 1);
        for (int i = 0; i < cut; i++)
          send_byte(key_pattern[i], i == cut - 1 && $urandom_range(0, 9) == 0);
        send_byte($urandom_range(0, 1) ? key_pattern[0] : 8'($urandom_range(0, 255)),
                  $urandom_range(0, 19) == 0);
        sent += cut + 1;
      end else if (kind == 9) begin
        send_byte(key_pattern[$urandom_range(0, key_span - 1)], 1'b0);
        sent++;
      end else begin
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
        sent++;
      end
    end
    settle();
  endtask

  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    in_ch.valid         = 1'b0;
    in_ch.data_byte     = '0;
    in_ch.end_of_stream = 1'b0;
    sender_idle_pct     = 0;
    stall_pct           = 10;
    steady_tail         = 1'b0;
    hold_off_req        = 1'b0;
    key_span            = KEY_LENGTH_RST;
    foreach (key_pattern[i]) key_pattern[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset key: one zero byte
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    settle();

    // key "--AB"
    write_reg(REG_KEY_WORD_BASE, 64'h0000_0000_4241_2D2D);
    write_reg(REG_KEY_LENGTH, 64'd4);
    send_byte(DASH, 1'b0); send_byte(DASH, 1'b0); send_byte(8'h41, 1'b0); send_byte(8'h42, 1'b0);
    send_byte(DASH, 1'b0); send_byte(DASH, 1'b0); send_byte(8'h41, 1'b0); send_byte(8'h43, 1'b0);
    // mismatch on a byte equal to the first key byte is held again
    send_byte(DASH, 1'b0); send_byte(DASH, 1'b0); send_byte(DASH, 1'b0);
    send_byte(8'hFF, 1'b0);
    // held prefix dropped at end of stream
    send_byte(DASH, 1'b0); send_byte(DASH, 1'b1);
    send_byte(DASH, 1'b0); send_byte(DASH, 1'b0); send_byte(8'h41, 1'b0); send_byte(8'h42, 1'b1);
    // count left above a shortened key
    send_byte(DASH, 1'b0); send_byte(DASH, 1'b0); send_byte(8'h41, 1'b0);
    settle();
    write_reg(REG_KEY_LENGTH, 64'd2);
    send_byte(8'h00, 1'b0);
    // key rewritten while a byte is held
    send_byte(DASH, 1'b0);
    settle();
    write_reg(REG_KEY_WORD_BASE, 64'h0000_0000_0000_7E11);
    send_byte(8'h55, 1'b0);
    settle();
    // zero length behaves as one
    write_reg(REG_KEY_LENGTH, 64'd0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h12, 1'b0);
    settle();

    run_phase(2, 1'b1, 30, 1'b1);
    run_phase(1, 1'b1, 25, 1'b0);
    run_phase($urandom_range(3, 8), 1'b1, 35, 1'b0);
    run_phase(KEY_BYTES, 1'b0, 20, 1'b0);
    run_phase(0, 1'b1, 20, 1'b0);
    run_phase(63, 1'b1, 20, 1'b0);
    run_phase($urandom_range(1, KEY_BYTES), $urandom_range(0, 1), 25, 1'b0);
    run_phase(4, 1'b1, 30, 1'b0);
    steady_tail = 1'b1;
    run_phase($urandom_range(2, 6), 1'b1, 25, 1'b0);

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
